// ===== sv/nmea_coordinate_field_to_degrees_macros.svh =====
`ifndef NMEA_COORDINATE_FIELD_TO_DEGREES_MACROS_SVH
`define NMEA_COORDINATE_FIELD_TO_DEGREES_MACROS_SVH

// same-cycle implication, disabled in reset
`define NCFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ncfd assertion failed");

// next-cycle implication, disabled in reset
`define NCFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ncfd assertion failed");

`endif

// ===== sv/ncfd_pkg.sv =====
package ncfd_pkg;

   localparam int MAX_INTEGER_DIGITS = 15;
   localparam int FRACTION_DIGITS    = 4;
   localparam int MINUTE_DIGITS      = 2;

   localparam int INT_CNT_W  = $clog2(MAX_INTEGER_DIGITS + 1);
   localparam int FRAC_CNT_W = $clog2(FRACTION_DIGITS + 1);

   localparam int CHAR_W  = 8;
   localparam int DEG_W   = 8;
   localparam int MIN_W   = 7;
   localparam int FRAC_W  = 14;
   localparam int SUM_W   = 27;
   localparam int QUOT_W  = 24;
   localparam int OUT_W   = 32;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

   localparam logic [OUT_W-1:0] DEG_SCALE  = 32'd10_000_000;
   localparam logic [SUM_W-1:0] MIN_SCALE  = 27'd1_000_000;
   localparam logic [SUM_W-1:0] FRAC_SCALE = 27'd100;

   // ceil(2^29 / 6); exact floor division for sums below 2^27
   localparam int              RECIP_SHIFT = 29;
   localparam logic [SUM_W-1:0] RECIP_SIX  = 27'd89_478_486;
   localparam logic [QUOT_W-1:0] QUOT_MAX  = 24'd16_666_650;
   localparam logic [OUT_W-1:0] RESULT_MAX = 32'd2_566_666_650;

   typedef struct packed {
      logic              too_long;
      logic [DEG_W-1:0]  degrees;
      logic [MIN_W-1:0]  minutes;
      logic [FRAC_W-1:0] fraction;
   } ncfd_fix_type;

   typedef struct packed {
      logic              too_long;
      logic [OUT_W-1:0]  deg_scaled;
      logic [QUOT_W-1:0] quotient;
   } ncfd_part_type;

   // zero-pad the fraction to four digits
   function automatic logic [FRAC_W-1:0] pad_scale(input logic [FRAC_CNT_W-1:0] cnt);
      logic [FRAC_W-1:0] r;
      case (32'(cnt))
         0:       r = 14'd10000;
         1:       r = 14'd1000;
         2:       r = 14'd100;
         3:       r = 14'd10;
         default: r = 14'd1;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/ncfd_parse.sv =====
module ncfd_parse import ncfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [CHAR_W-1:0] in_char,
   input  logic              in_last,
   output logic              in_ready,
   output logic              fix_valid,
   output ncfd_fix_type      fix,
   input  logic              fix_ready
);

   typedef enum logic [1:0] {
      PH_INTEGER,
      PH_FRACTION,
      PH_STOPPED,
      PH_TOO_LONG
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [INT_CNT_W-1:0]  icnt_ff, icnt_in;
   logic [MIN_W-1:0]      held_ff, held_in;
   logic [DEG_W-1:0]      deg_ff, deg_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [FRAC_CNT_W-1:0] fcnt_ff, fcnt_in;
   logic                  fix_valid_ff, fix_valid_in;
   ncfd_fix_type          fix_ff, fix_in;

   logic       take;
   logic       is_digit;
   logic [3:0] digit;
   logic [3:0] oldest;
   logic [3:0] youngest;

   assign in_ready = !fix_valid_ff || fix_ready;
   assign take     = in_valid && in_ready;
   assign is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
   assign digit    = is_digit ? in_char[3:0] : 4'd0;
   // held value is at most 99: x/10 == (x*205)>>11
   assign oldest   = 4'((16'(held_ff) * 16'd205) >> 11);
   assign youngest = 4'(held_ff - 7'(oldest) * 7'd10);

   always_comb begin
      phase_in     = phase_ff;
      icnt_in      = icnt_ff;
      held_in      = held_ff;
      deg_in       = deg_ff;
      frac_in      = frac_ff;
      fcnt_in      = fcnt_ff;
      fix_valid_in = fix_ready ? 1'b0 : fix_valid_ff;
      fix_in       = fix_ff;

      if (take) begin
         unique case (phase_ff)
            PH_INTEGER: begin
               if (is_digit) begin
                  if (icnt_ff >= INT_CNT_W'(MAX_INTEGER_DIGITS)) begin
                     phase_in = PH_TOO_LONG;
                  end else begin
                     if (icnt_ff >= INT_CNT_W'(MINUTE_DIGITS)) begin
                        deg_in  = 8'(deg_ff * 8'd10) + 8'(oldest);
                        held_in = 7'(youngest) * 7'd10 + 7'(digit);
                     end else begin
                        held_in = 7'(held_ff * 7'd10) + 7'(digit);
                     end
                     icnt_in = icnt_ff + INT_CNT_W'(1);
                  end
               end else if (in_char == CHAR_DOT) begin
                  phase_in = PH_FRACTION;
               end else begin
                  phase_in = PH_STOPPED;
               end
            end
            PH_FRACTION: begin
               if (is_digit) begin
                  if (fcnt_ff < FRAC_CNT_W'(FRACTION_DIGITS)) begin
                     frac_in = 14'(frac_ff * 14'd10) + 14'(digit);
                     fcnt_in = fcnt_ff + FRAC_CNT_W'(1);
                  end
               end else begin
                  phase_in = PH_STOPPED;
               end
            end
            PH_STOPPED, PH_TOO_LONG: begin
            end
         endcase

         if (in_last) begin
            fix_valid_in     = 1'b1;
            fix_in.too_long  = (phase_in == PH_TOO_LONG);
            fix_in.degrees   = deg_in;
            fix_in.minutes   = held_in;
            fix_in.fraction  = 14'(frac_in * pad_scale(fcnt_in));
            phase_in         = PH_INTEGER;
            icnt_in          = '0;
            held_in          = '0;
            deg_in           = '0;
            frac_in          = '0;
            fcnt_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_INTEGER;
         icnt_ff      <= '0;
         held_ff      <= '0;
         deg_ff       <= '0;
         frac_ff      <= '0;
         fcnt_ff      <= '0;
         fix_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         icnt_ff      <= icnt_in;
         held_ff      <= held_in;
         deg_ff       <= deg_in;
         frac_ff      <= frac_in;
         fcnt_ff      <= fcnt_in;
         fix_valid_ff <= fix_valid_in;
      end
      fix_ff <= fix_in;
   end

   assign fix_valid = fix_valid_ff;
   assign fix       = fix_ff;

endmodule

// ===== sv/ncfd_scale.sv =====
module ncfd_scale import ncfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fix_valid,
   input  ncfd_fix_type  fix,
   output logic          fix_ready,
   output logic          part_valid,
   output ncfd_part_type part,
   input  logic          part_ready
);

   // stage 1: minutes and fraction scaled to 1e-6 minute, degrees to 1e-7 degree
   logic              sum_valid_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [OUT_W-1:0]  degs_ff, degs_in;
   logic              tl_ff;
   logic              sum_ready;

   // stage 2: sum / 6 by reciprocal multiply
   logic                 part_valid_ff;
   ncfd_part_type        part_ff, part_in;
   logic [2*SUM_W-1:0]   product;

   assign sum_ready = !part_valid_ff || part_ready;
   assign fix_ready = !sum_valid_ff || sum_ready;

   assign sum_in  = 27'(fix.minutes) * MIN_SCALE + 27'(fix.fraction) * FRAC_SCALE;
   assign degs_in = 32'(fix.degrees) * DEG_SCALE;

   assign product = 54'(sum_ff) * 54'(RECIP_SIX);

   always_comb begin
      part_in.too_long   = tl_ff;
      part_in.deg_scaled = degs_ff;
      part_in.quotient   = product[RECIP_SHIFT +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         part_valid_ff <= 1'b0;
      end else begin
         if (fix_ready) begin
            sum_valid_ff <= fix_valid;
         end
         if (sum_ready) begin
            part_valid_ff <= sum_valid_ff;
         end
      end
      if (fix_ready && fix_valid) begin
         sum_ff  <= sum_in;
         degs_ff <= degs_in;
         tl_ff   <= fix.too_long;
      end
      if (sum_ready && sum_valid_ff) begin
         part_ff <= part_in;
      end
   end

   assign part_valid = part_valid_ff;
   assign part       = part_ff;

endmodule

// ===== sv/nmea_coordinate_field_to_degrees.sv =====
// NMEA coordinate field (DDDMM.mmmm) to degrees in units of 1e-7 degree. Send the
// field's characters one per request on req_tdata, with req_tlast on the last one;
// that request yields one response: degrees*10^7 + (minutes*10^6 + fraction*100)/6,
// or 0 with rsp_tuser set when sixteen or more integer digits came. Degrees wrap
// modulo 256. One request is taken every clock cycle unless rsp_tready holds back
// the pipeline; a response goes through the input register, parser, scaling stage,
// reciprocal-multiply stage and output register. No startup delay after reset.
`include "nmea_coordinate_field_to_degrees_macros.svh"

module nmea_coordinate_field_to_degrees import ncfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_field
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] degrees_e7
   output logic        rsp_tuser    // [0] too_long
);

   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;
   logic              parse_ready;

   logic              fix_valid;
   ncfd_fix_type      fix;
   logic              fix_ready;

   logic              part_valid;
   ncfd_part_type     part;
   logic              part_ready;

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff;

   assign req_tready = !in_valid_ff || parse_ready;
   assign part_ready = !rsp_valid_ff || rsp_tready;

   ncfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_char   (in_char_ff),
      .in_last   (in_last_ff),
      .in_ready  (parse_ready),
      .fix_valid (fix_valid),
      .fix       (fix),
      .fix_ready (fix_ready)
   );

   ncfd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .fix_valid  (fix_valid),
      .fix        (fix),
      .fix_ready  (fix_ready),
      .part_valid (part_valid),
      .part       (part),
      .part_ready (part_ready)
   );

   assign rsp_data_in = part.too_long ? '0 : part.deg_scaled + 32'(part.quotient);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (part_ready) begin
            rsp_valid_ff <= part_valid;
         end
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (part_ready && part_valid) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= part.too_long;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `NCFD_ASSERT_NOW(a_too_long_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `NCFD_ASSERT_NOW(a_result_bound, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata <= RESULT_MAX)
   `NCFD_ASSERT_NOW(a_quot_bound, clock, reset, part_valid, part.quotient <= QUOT_MAX)
   `NCFD_ASSERT_NEXT(a_last_to_fix, clock, reset, in_valid_ff && parse_ready && in_last_ff, fix_valid)

endmodule

// ===== tb/nmea_coordinate_field_to_degrees_tb.sv =====
module nmea_coordinate_field_to_degrees_tb import ncfd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS = 17;
   localparam int RANDOM_CHARS  = 1000;

   typedef enum logic [1:0] {
      PH_INTEGER,
      PH_FRACTION,
      PH_STOPPED,
      PH_TOO_LONG
   } parse_phase_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_TOGGLE
   } ready_pattern_type;

   typedef struct packed {
      logic [31:0] degrees_e7;
      logic        too_long;
   } coord_result_type;

   typedef struct {
      logic [7:0]  code;
      int          reps;
      logic        last;
      bit          typed;
      logic [31:0] value;
      logic        flag;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   // parser copy
   parse_phase_type phase      = PH_INTEGER;
   logic [4:0]   int_count  = '0;
   logic [7:0]   minute_hold = '0;
   logic [7:0]   deg_acc    = '0;
   logic [13:0]  frac_acc   = '0;
   logic [2:0]   frac_count = '0;

   coord_result_type  pending_results [$];
   stim_row_type      directed_rows [DIRECTED_ROWS];
   int             error_count       = 0;
   int             chars_sent        = 0;
   int             responses_checked = 0;
   int             too_long_checked  = 0;
   int             burst_left        = 1;
   ready_pattern_type ready_pattern  = READY_ALWAYS;
   int             pattern_left      = 0;

   nmea_coordinate_field_to_degrees i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic void clear_parser();
      phase       = PH_INTEGER;
      int_count   = '0;
      minute_hold = '0;
      deg_acc     = '0;
      frac_acc    = '0;
      frac_count  = '0;
   endfunction

   // returns 1 when the character closes a field
   function automatic bit take_coordinate_char(input logic [7:0] code, input logic last,
                                               output coord_result_type result);
      logic        is_digit;
      logic [3:0]  d;
      logic [31:0] frac;
      int          i;
      is_digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
      d = is_digit ? 4'(code - CHAR_ZERO) : 4'd0;
      case (phase)
         PH_INTEGER: begin
            if (is_digit) begin
               if (int_count >= MAX_INTEGER_DIGITS) begin
                  phase = PH_TOO_LONG;
               end else begin
                  if (int_count >= 2) begin
                     deg_acc     = 8'(deg_acc * 10 + minute_hold / 10);
                     minute_hold = 8'((minute_hold % 10) * 10 + d);
                  end else begin
                     minute_hold = 8'(minute_hold * 10 + d);
                  end
                  int_count = int_count + 5'd1;
               end
            end else if (code == CHAR_DOT) begin
               phase = PH_FRACTION;
            end else begin
               phase = PH_STOPPED;
            end
         end
         PH_FRACTION: begin
            if (is_digit) begin
               if (frac_count < FRACTION_DIGITS) begin
                  frac_acc   = 14'(frac_acc * 10 + d);
                  frac_count = frac_count + 3'd1;
               end
            end else begin
               phase = PH_STOPPED;
            end
         end
         default: ;
      endcase
      result = '0;
      if (!last) return 0;
      if (phase == PH_TOO_LONG) begin
         result.too_long = 1'b1;
      end else begin
         frac = 32'(frac_acc);
         for (i = frac_count; i < 4; i++) frac = frac * 32'd10;
         result.degrees_e7 = 32'(deg_acc) * DEG_SCALE
                           + (32'(minute_hold) * 32'd1_000_000 + frac * 32'd100) / 32'd6;
      end
      clear_parser();
      return 1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   // one request; returns on a falling edge once taken; a burst end drops tvalid
   task automatic send_char(input logic [7:0] code, input logic last, input bit typed,
                            input coord_result_type typed_result);
      coord_result_type predicted;
      req_tdata  = code;
      req_tlast  = last;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      if (take_coordinate_char(code, last, predicted))
         pending_results.push_back(typed ? typed_result : predicted);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic drain_pending();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_field();
      logic [7:0] text [$];
      logic [7:0] junk;
      int         kind;
      int         n_int;
      int         n_frac;
      int         i;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         // noise
         repeat ($urandom_range(1, 4))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
         return;
      end
      i = $urandom_range(0, 99);
      if (i < 60)      n_int = $urandom_range(4, 5);
      else if (i < 75) n_int = $urandom_range(0, 3);
      else if (i < 90) n_int = $urandom_range(6, 15);
      else             n_int = $urandom_range(16, 20);
      repeat (n_int) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) < 8) begin
         text.push_back(CHAR_DOT);
         n_frac = $urandom_range(0, 6);
         repeat (n_frac) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if (kind < 25 || text.size() == 0) begin
         do junk = 8'($urandom_range(0, 255));
         while (junk >= CHAR_ZERO && junk <= CHAR_NINE);
         text.insert($urandom_range(0, text.size()), junk);
      end
      for (i = 0; i < text.size(); i++)
         send_char(text[i], i == text.size() - 1, 1'b0, '0);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         ready_pattern = ready_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(20, 150);
      end else begin
         pattern_left--;
      end
      case (ready_pattern)
         READY_ALWAYS: rsp_tready = 1'b1;
         READY_COIN:   rsp_tready = 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready = ($urandom_range(0, 5) == 0);
         default:      rsp_tready = ~rsp_tready;
      endcase
   end

   always @(posedge clock) begin : response_check
      coord_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            responses_checked++;
            if (want.too_long) too_long_checked++;
            if (rsp_tdata !== want.degrees_e7)
               report_mismatch("degrees_e7", want.degrees_e7, rsp_tdata);
            if (rsp_tuser !== want.too_long)
               report_mismatch("too_long", 32'(want.too_long), 32'(rsp_tuser));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("nmea_coordinate_field_to_degrees verification failed");
      $finish;
   end

   initial begin
      int  r;
      int  k;
      int  random_end;
      bit  paused;
      directed_rows = '{
         '{"3",      1, 1'b0, 1'b0, 32'd0,       1'b0},
         '{8'hFF,    1, 1'b1, 1'b1, 32'd500_000, 1'b0},  // minutes only, stop char
         '{"2",      1, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"5",      2, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"9",      2, 1'b0, 1'b0, 32'd0,       1'b0},
         '{CHAR_DOT, 1, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"9",      4, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"9",      1, 1'b1, 1'b1, RESULT_MAX,  1'b0},  // extra fraction digit
         '{"9",     15, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"9",      1, 1'b1, 1'b1, 32'd0,       1'b1},  // sixteenth digit
         '{CHAR_DOT, 1, 1'b1, 1'b1, 32'd0,       1'b0},
         '{8'h00,    1, 1'b1, 1'b1, 32'd0,       1'b0},
         '{"1",      1, 1'b0, 1'b0, 32'd0,       1'b0},
         '{CHAR_DOT, 1, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"2",      1, 1'b0, 1'b0, 32'd0,       1'b0},
         '{"z",      1, 1'b0, 1'b0, 32'd0,       1'b0},  // stop inside fraction
         '{"4",      1, 1'b1, 1'b0, 32'd0,       1'b0}
      };
      clear_parser();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      burst_left = $urandom_range(1, 40);

      for (r = 0; r < DIRECTED_ROWS; r++)
         for (k = 0; k < directed_rows[r].reps; k++)
            send_char(directed_rows[r].code,
                      directed_rows[r].last && (k == directed_rows[r].reps - 1),
                      directed_rows[r].typed && (k == directed_rows[r].reps - 1),
                      '{directed_rows[r].value, directed_rows[r].flag});
      drain_pending();

      random_end = chars_sent + RANDOM_CHARS;
      paused = 1'b0;
      while (chars_sent < random_end) begin
         send_random_field();
         if (!paused && chars_sent >= random_end - RANDOM_CHARS / 2) begin
            drain_pending();
            paused = 1'b1;
         end
      end
      req_tvalid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run covered %0d characters and %0d checked fields, %0d of them too long",
               chars_sent, responses_checked, too_long_checked);
      if (error_count == 0) begin
         $display("nmea_coordinate_field_to_degrees verification clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("nmea_coordinate_field_to_degrees verification failed");
      end
      $finish;
   end

endmodule
